// ===== rtl/phr_pkg.sv =====
// Package for the pixel hue replacement block: pixel payload types,
// hue sector codes and the fixed constants of the divide-by-60 step.
// No dependencies.
`timescale 1ns / 1ps

package phr_pkg;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_pixel_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_pixel_t;

  // One code per 60 degree slice of the color wheel.
  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } sector_e;

  typedef struct packed {
    sector_e    sector;
    logic [5:0] rem;
  } hue_cfg_t;

  localparam int unsigned HueW         = 9;
  localparam int unsigned DegPerSector = 60;
  localparam int unsigned FullTurn     = 360;
  // floor(x / 60) == (x * Recip60) >> Recip60Shift for every x below 23831
  localparam int unsigned Recip60      = 17477;
  localparam int unsigned Recip60Shift = 20;

endpackage

// ===== rtl/phr_hue_cfg.sv =====
// Hue configuration register: folds the written hue into 0..359 and keeps
// it as sector code and remainder within the sector. Uses phr_pkg.
`timescale 1ns / 1ps

module phr_hue_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [phr_pkg::HueW-1:0]       cfg_data_i,
  output phr_pkg::hue_cfg_t              hue_cfg_o
);

  logic [phr_pkg::HueW-1:0] hue;
  phr_pkg::hue_cfg_t        hue_cfg_d;
  phr_pkg::hue_cfg_t        hue_cfg_q;

  always_comb begin
    if (cfg_data_i >= phr_pkg::HueW'(phr_pkg::FullTurn)) begin
      hue = cfg_data_i - phr_pkg::HueW'(phr_pkg::FullTurn);
    end else begin
      hue = cfg_data_i;
    end
    // pick the slice from the top down
    priority if (hue >= phr_pkg::HueW'(5 * phr_pkg::DegPerSector)) begin
      hue_cfg_d.sector = phr_pkg::SEC_MAGENTA_RED;
      hue_cfg_d.rem    = 6'(hue - phr_pkg::HueW'(5 * phr_pkg::DegPerSector));
    end else if (hue >= phr_pkg::HueW'(4 * phr_pkg::DegPerSector)) begin
      hue_cfg_d.sector = phr_pkg::SEC_BLUE_MAGENTA;
      hue_cfg_d.rem    = 6'(hue - phr_pkg::HueW'(4 * phr_pkg::DegPerSector));
    end else if (hue >= phr_pkg::HueW'(3 * phr_pkg::DegPerSector)) begin
      hue_cfg_d.sector = phr_pkg::SEC_CYAN_BLUE;
      hue_cfg_d.rem    = 6'(hue - phr_pkg::HueW'(3 * phr_pkg::DegPerSector));
    end else if (hue >= phr_pkg::HueW'(2 * phr_pkg::DegPerSector)) begin
      hue_cfg_d.sector = phr_pkg::SEC_GREEN_CYAN;
      hue_cfg_d.rem    = 6'(hue - phr_pkg::HueW'(2 * phr_pkg::DegPerSector));
    end else if (hue >= phr_pkg::HueW'(phr_pkg::DegPerSector)) begin
      hue_cfg_d.sector = phr_pkg::SEC_YELLOW_GREEN;
      hue_cfg_d.rem    = 6'(hue - phr_pkg::HueW'(phr_pkg::DegPerSector));
    end else begin
      hue_cfg_d.sector = phr_pkg::SEC_RED_YELLOW;
      hue_cfg_d.rem    = 6'(hue);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_cfg_q.sector <= phr_pkg::SEC_RED_YELLOW;
      hue_cfg_q.rem    <= '0;
    end else if (cfg_we_i) begin
      hue_cfg_q <= hue_cfg_d;
    end
  end

  assign hue_cfg_o = hue_cfg_q;

endmodule

// ===== rtl/pixel_hue_replace.sv =====
// Top level of the pixel hue replacement block: four-stage pixel pipeline.
// Depends on phr_pkg and phr_hue_cfg.
`timescale 1ns / 1ps

// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  in_data_i  (in_red, in_green, in_blue)
// out      output     out_valid_o / out_stall_i out_data_o (out_red, out_green, out_blue)
// cfg      input      cfg_we_i                 cfg_data_i (target_hue)
//
// One pixel per clock while the output does not stall; an accepted pixel passes through each stage register in turn.
// Stages: max/min, sector products, divide by 60 via reciprocal multiplier,
// final subtract and channel placement into the output register.
// Each stage advances on its own, so bubbles close up while the output stalls.
// Reset clears the valid bits and sets the hue to 0; no clearing pass.

module pixel_hue_replace (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  phr_pkg::in_pixel_t       in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output phr_pkg::out_pixel_t      out_data_o,
  input  logic                     cfg_we_i,
  input  logic [phr_pkg::HueW-1:0] cfg_data_i
);

  phr_pkg::hue_cfg_t hue_cfg;

  phr_hue_cfg u_hue_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .hue_cfg_o  (hue_cfg)
  );

  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, v4_q;

  // stage payloads
  logic [7:0]  s1_mx_q, s1_mn_q, s1_d_q;
  logic [7:0]  s2_mx_q, s2_mn_q;
  logic [13:0] s2_pq_q, s2_pt_q;
  logic [7:0]  s3_mx_q, s3_mn_q, s3_cq_q, s3_ct_q;
  phr_pkg::out_pixel_t s4_q;

  logic [7:0]  mx_d, mn_d;
  logic [6:0]  rem_c;
  logic [13:0] xq, xt;
  logic [28:0] mq, mt;
  logic [7:0]  qv, tv;
  phr_pkg::out_pixel_t s4_d;

  assign en4 = !v4_q || !out_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  always_comb begin
    mx_d = in_data_i.in_red;
    if (in_data_i.in_green > mx_d) mx_d = in_data_i.in_green;
    if (in_data_i.in_blue > mx_d)  mx_d = in_data_i.in_blue;
    mn_d = in_data_i.in_red;
    if (in_data_i.in_green < mn_d) mn_d = in_data_i.in_green;
    if (in_data_i.in_blue < mn_d)  mn_d = in_data_i.in_blue;
  end

  assign rem_c = 7'(phr_pkg::DegPerSector) - {1'b0, hue_cfg.rem};

  // ceil(n / 60) as floor((n + 59) / 60)
  assign xq = s2_pq_q + 14'(phr_pkg::DegPerSector - 1);
  assign xt = s2_pt_q + 14'(phr_pkg::DegPerSector - 1);
  assign mq = {15'd0, xq} * 29'(phr_pkg::Recip60);
  assign mt = {15'd0, xt} * 29'(phr_pkg::Recip60);

  assign qv = s3_mx_q - s3_cq_q;
  assign tv = s3_mx_q - s3_ct_q;

  always_comb begin
    unique case (hue_cfg.sector)
      phr_pkg::SEC_RED_YELLOW:   s4_d = '{out_red: s3_mx_q, out_green: tv,      out_blue: s3_mn_q};
      phr_pkg::SEC_YELLOW_GREEN: s4_d = '{out_red: qv,      out_green: s3_mx_q, out_blue: s3_mn_q};
      phr_pkg::SEC_GREEN_CYAN:   s4_d = '{out_red: s3_mn_q, out_green: s3_mx_q, out_blue: tv};
      phr_pkg::SEC_CYAN_BLUE:    s4_d = '{out_red: s3_mn_q, out_green: qv,      out_blue: s3_mx_q};
      phr_pkg::SEC_BLUE_MAGENTA: s4_d = '{out_red: tv,      out_green: s3_mn_q, out_blue: s3_mx_q};
      default:                   s4_d = '{out_red: s3_mx_q, out_green: s3_mn_q, out_blue: qv};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_mx_q <= mx_d;
      s1_mn_q <= mn_d;
      s1_d_q  <= mx_d - mn_d;
    end
    if (en2) begin
      s2_mx_q <= s1_mx_q;
      s2_mn_q <= s1_mn_q;
      s2_pq_q <= 14'({6'd0, s1_d_q} * {8'd0, hue_cfg.rem});
      s2_pt_q <= 14'({6'd0, s1_d_q} * {7'd0, rem_c});
    end
    if (en3) begin
      s3_mx_q <= s2_mx_q;
      s3_mn_q <= s2_mn_q;
      s3_cq_q <= mq[phr_pkg::Recip60Shift +: 8];
      s3_ct_q <= mt[phr_pkg::Recip60Shift +: 8];
    end
    if (en4) begin
      s4_q <= s4_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = s4_q;

endmodule

// ===== rtl/phr_checker.sv =====
// Port-level checker for pixel_hue_replace, attached by the bind below.
// Depends on phr_pkg and the top level's ports.
`timescale 1ns / 1ps

module phr_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input phr_pkg::out_pixel_t      out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output item changed or dropped");

  // input backs up only when the whole pipe is full behind a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output side can move");

  // an accepted item reaches the output when the output side does not stall meanwhile
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      |=> out_valid_o)
    else $error("accepted item did not reach the output");

  // nothing comes out of an empty pipe
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_i ##1 !in_valid_i ##1 !in_valid_i ##1 !in_valid_i ##1 !out_valid_o
      ##1 !in_valid_i |-> !out_valid_o || !$rose(out_valid_o))
    else $error("output item appeared without input");

endmodule

bind pixel_hue_replace phr_checker u_phr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== bench/hue_replace_checker.sv =====
// Scoreboard for pixel_hue_replace: mirrors the hue register, predicts every
// recolored pixel and compares results in order. Depends on phr_pkg.
`timescale 1ns / 1ps

module hue_replace_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  phr_pkg::in_pixel_t       in_data_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  phr_pkg::out_pixel_t      out_data_i,
  input  logic                     cfg_we_i,
  input  logic [phr_pkg::HueW-1:0] cfg_data_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o
);

  phr_pkg::out_pixel_t      recolor_q[$];
  logic [phr_pkg::HueW-1:0] hue_mirror;

  // Keep value (max) and spread (max - min), put the pixel on the given hue.
  function automatic phr_pkg::out_pixel_t recolor_pixel(phr_pkg::in_pixel_t px,
                                                        logic [phr_pkg::HueW-1:0] hue_reg);
    logic [7:0]               mx, mn, d, p, q, t;
    logic [phr_pkg::HueW-1:0] hue;
    phr_pkg::sector_e         sec;
    int unsigned              rem;
    phr_pkg::out_pixel_t      res;
    mx = px.in_red;
    if (px.in_green > mx) mx = px.in_green;
    if (px.in_blue > mx) mx = px.in_blue;
    mn = px.in_red;
    if (px.in_green < mn) mn = px.in_green;
    if (px.in_blue < mn) mn = px.in_blue;
    d = mx - mn;
    // wrap 360..511 back onto the wheel once
    hue = (hue_reg >= phr_pkg::FullTurn) ?
          phr_pkg::HueW'(hue_reg - phr_pkg::FullTurn) : hue_reg;
    sec = phr_pkg::sector_e'(hue / phr_pkg::DegPerSector);
    rem = hue % phr_pkg::DegPerSector;
    p = mn;
    q = mx - 8'((d * rem + phr_pkg::DegPerSector - 1) / phr_pkg::DegPerSector);
    t = mx - 8'((d * (phr_pkg::DegPerSector - rem) + phr_pkg::DegPerSector - 1) /
                phr_pkg::DegPerSector);
    case (sec)
      phr_pkg::SEC_RED_YELLOW:   res = '{mx, t, p};
      phr_pkg::SEC_YELLOW_GREEN: res = '{q, mx, p};
      phr_pkg::SEC_GREEN_CYAN:   res = '{p, mx, t};
      phr_pkg::SEC_CYAN_BLUE:    res = '{p, q, mx};
      phr_pkg::SEC_BLUE_MAGENTA: res = '{t, p, mx};
      default:                   res = '{mx, p, q};
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    phr_pkg::out_pixel_t want;
    if (!rst_ni) begin
      recolor_q.delete();
      hue_mirror   = '0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (recolor_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: result %h arrived with no pixel pending", $time, out_data_i);
          fail_count_o++;
        end else begin
          want = recolor_q.pop_front();
          if (want.out_red !== out_data_i.out_red || want.out_green !== out_data_i.out_green ||
              want.out_blue !== out_data_i.out_blue) begin
            if (fail_count_o < 10)
              $display("%0t: pixel mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                       $time, want.out_red, want.out_green, want.out_blue,
                       out_data_i.out_red, out_data_i.out_green, out_data_i.out_blue);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        recolor_q.push_back(recolor_pixel(in_data_i, hue_mirror));
      if (cfg_we_i)
        hue_mirror = cfg_data_i;
      pending_o = recolor_q.size();
    end
  end

endmodule

// ===== bench/pixel_hue_replace_tb.sv =====
// Testbench top for pixel_hue_replace: drives pixels and hue settings with
// random idling on both sides; depends on phr_pkg and hue_replace_checker.
`timescale 1ns / 1ps

module pixel_hue_replace_tb;

  localparam int unsigned PipeDepth   = 4;
  localparam int unsigned PhaseLength = 64;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  phr_pkg::in_pixel_t       in_data = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  phr_pkg::out_pixel_t      out_data;
  logic                     cfg_we = 1'b0;
  logic [phr_pkg::HueW-1:0] cfg_data = '0;
  int unsigned              fail_count;
  int unsigned              pending;
  bit                       no_idle_in = 1'b0;
  bit                       no_idle_out = 1'b0;

  phr_pkg::in_pixel_t corner_px[12] = '{
    '{8'h00, 8'h00, 8'h00}, '{8'hFF, 8'hFF, 8'hFF}, '{8'h80, 8'h80, 8'h80},
    '{8'hFF, 8'h00, 8'h00}, '{8'h00, 8'hFF, 8'h00}, '{8'h00, 8'h00, 8'hFF},
    '{8'hFF, 8'hFF, 8'h00}, '{8'h00, 8'hFF, 8'hFF}, '{8'hFF, 8'h00, 8'hFF},
    '{8'h01, 8'h00, 8'h00}, '{8'hFE, 8'hFF, 8'h01}, '{8'h7F, 8'h3A, 8'hC5}
  };

  logic [phr_pkg::HueW-1:0] hue_plan[12] = '{
    9'd60, 9'd1, 9'd119, 9'd180, 9'd239, 9'd300,
    9'd59, 9'd360, 9'd511, 9'd30, 9'd420, 9'd0
  };

  pixel_hue_replace dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  hue_replace_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Mostly random pixels, with grays, saturated corners and near-grays mixed in.
  function automatic phr_pkg::in_pixel_t random_pixel();
    phr_pkg::in_pixel_t px;
    logic [7:0]         base;
    px   = phr_pkg::in_pixel_t'($urandom);
    base = 8'($urandom_range(0, 250));
    case ($urandom_range(0, 7))
      0: px = '{base, base, base};
      1: begin
        px.in_red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        px.in_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        px.in_blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      2: px = '{base + 8'($urandom_range(0, 5)), base + 8'($urandom_range(0, 5)),
                base + 8'($urandom_range(0, 5))};
      default: ;
    endcase
    return px;
  endfunction

  // Called and returns at a falling edge; holds the item until accepted.
  task automatic send_pixel(phr_pkg::in_pixel_t px);
    int unsigned gap;
    gap = no_idle_in ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drain the pipeline, then load a new hue.
  task automatic write_hue(logic [phr_pkg::HueW-1:0] hue);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= hue;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic run_phase(logic [phr_pkg::HueW-1:0] hue);
    write_hue(hue);
    no_idle_in  = ($urandom_range(0, 3) == 0);
    no_idle_out = ($urandom_range(0, 3) == 0);
    repeat (PhaseLength) send_pixel(random_pixel());
  endtask

  // Receiver: draw a stall length per result, then wait for the result.
  initial begin
    int unsigned hold;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      hold = no_idle_out ? 0 : $urandom_range(0, 19);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (corner_px[i]) send_pixel(corner_px[i]);
    write_hue(9'd359);
    foreach (corner_px[i]) send_pixel(corner_px[i]);
    foreach (hue_plan[i]) run_phase(hue_plan[i]);
    repeat (4) run_phase(phr_pkg::HueW'($urandom_range(0, 511)));
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2 * PipeDepth) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("pixel_hue_replace verification clean");
    end else begin
      $display("pixel_hue_replace verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("pixel_hue_replace verification failed");
    $finish;
  end

endmodule
